// ----- hw/rtl/okss_pkg.sv -----
// Shared types, widths, command codes and a helper function for the ordered key set.
`timescale 1ns / 1ps

package okss_pkg;

  // Field widths of the item and result channels.
  localparam int unsigned KEY_W  = 10;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CMD_W  = 2;

  // Presence map geometry: one 32-bit word per cluster, one summary bit per cluster.
  localparam int unsigned OFF_W   = 5;
  localparam int unsigned CLUS_W  = KEY_W - OFF_W;
  localparam int unsigned WORD_W  = 1 << OFF_W;
  localparam int unsigned NCLUST  = 1 << CLUS_W;
  localparam int unsigned NKEYS   = 1 << KEY_W;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SUCC   = 2'd2;

  // Query presented to the presence map by the first pipeline stage.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
  } okss_req_t;

  // Presence map update for an insert leaving the first stage.
  typedef struct packed {
    logic             we;
    logic [KEY_W-1:0] key;
  } okss_upd_t;

  // Answer of the presence map: whether a key was found and which one.
  typedef struct packed {
    logic             found;
    logic [KEY_W-1:0] key;
  } okss_res_t;

  // Index of the lowest set bit of a word; zero when the word is empty.
  function automatic logic [OFF_W-1:0] lowest_bit(input logic [WORD_W-1:0] w);
    logic [OFF_W-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        r = OFF_W'(i);
      end
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/okss_data_ram.sv -----
// Data word store: one write port and one registered read port, not cleared at reset.
`timescale 1ns / 1ps

module okss_data_ram (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [okss_pkg::KEY_W-1:0]  waddr_i,
  input  logic [okss_pkg::DATA_W-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [okss_pkg::KEY_W-1:0]  raddr_i,
  output logic [okss_pkg::DATA_W-1:0] rdata_o
);
  import okss_pkg::*;

  logic [DATA_W-1:0] mem_q [NKEYS];
  logic [DATA_W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds while no read is enabled.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/okss_presence.sv -----
// Two-level presence map with per-cluster minimum, answering lookup and successor queries.
`timescale 1ns / 1ps

module okss_presence (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  okss_pkg::okss_req_t req_i,
  input  okss_pkg::okss_upd_t upd_i,
  output okss_pkg::okss_res_t res_o
);
  import okss_pkg::*;

  logic [WORD_W-1:0] cluster_q [NCLUST];
  logic [NCLUST-1:0] summary_q;
  logic [OFF_W-1:0]  min_q [NCLUST];

  logic [KEY_W:0]    next_key;
  logic              last_key;
  logic [CLUS_W-1:0] rd_clus;
  logic [WORD_W-1:0] rd_word;
  logic [WORD_W-1:0] tail_word;
  logic [NCLUST-1:0] later_clus;
  logic [CLUS_W-1:0] next_clus;
  logic [CLUS_W-1:0] wr_clus;
  logic [OFF_W-1:0]  wr_off;
  logic [NCLUST-1:0] nonempty;

  // Read side: one cluster word at the query's cluster (the next key's cluster for a successor),
  // one minimum at the next non-empty cluster above it, taken from the summary.
  always_comb begin
    next_key   = {1'b0, req_i.key} + (KEY_W + 1)'(1);
    last_key   = (req_i.key == {KEY_W{1'b1}});
    rd_clus    = (req_i.cmd == CMD_SUCC) ? next_key[KEY_W-1:OFF_W] : req_i.key[KEY_W-1:OFF_W];
    rd_word    = cluster_q[rd_clus];
    tail_word  = rd_word & ({WORD_W{1'b1}} << next_key[OFF_W-1:0]);
    later_clus = summary_q & (({NCLUST{1'b1}} << rd_clus) << 1);
    next_clus  = lowest_bit(later_clus);
  end

  // Answer selection per command.
  always_comb begin
    res_o = '0;
    case (req_i.cmd)
      CMD_INSERT: begin
        res_o.found = 1'b1;
        res_o.key   = req_i.key;
      end
      CMD_LOOKUP: begin
        res_o.found = rd_word[req_i.key[OFF_W-1:0]];
        res_o.key   = req_i.key;
      end
      CMD_SUCC: begin
        if (last_key) begin
          res_o = '0;
        end else if (|tail_word) begin
          res_o.found = 1'b1;
          res_o.key   = {rd_clus, lowest_bit(tail_word)};
        end else if (|later_clus) begin
          res_o.found = 1'b1;
          res_o.key   = {next_clus, min_q[next_clus]};
        end
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

  assign wr_clus = upd_i.key[KEY_W-1:OFF_W];
  assign wr_off  = upd_i.key[OFF_W-1:0];

  // Presence bits and summary, cleared at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NCLUST; i++) begin
        cluster_q[i] <= '0;
      end
      summary_q <= '0;
    end else if (upd_i.we) begin
      cluster_q[wr_clus] <= cluster_q[wr_clus] | (WORD_W'(1) << wr_off);
      summary_q[wr_clus] <= 1'b1;
    end
  end

  // Smallest offset per cluster; only read while the cluster's summary bit is set.
  always_ff @(posedge clk_i) begin
    if (upd_i.we) begin
      if (!summary_q[wr_clus] || (wr_off < min_q[wr_clus])) begin
        min_q[wr_clus] <= wr_off;
      end
    end
  end

  // Which clusters hold any key, for checking the summary.
  always_comb begin
    for (int i = 0; i < NCLUST; i++) begin
      nonempty[i] = |cluster_q[i];
    end
  end

  // The summary always mirrors the cluster words.
  a_summary_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    summary_q == nonempty)
    else $error("summary disagrees with cluster words");

  // An insert leaves its key marked present.
  a_insert_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i.we |=> cluster_q[$past(wr_clus)][$past(wr_off)])
    else $error("inserted key not marked present");

  // A successor found lies strictly above the searched key.
  a_succ_above: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.found && (req_i.cmd == CMD_SUCC)) |-> (res_o.key > req_i.key))
    else $error("successor not above searched key");

endmodule

// ----- hw/rtl/ordered_key_set_successor_core.sv -----
// Top level of the ordered key set: input stage, presence map, data store and result stage.
`timescale 1ns / 1ps
// A result becomes valid once its item has passed the input register and the result register.
// One item per cycle is taken while the result stage is free or the output is ready; the
// presence map is searched combinationally between the input register and the result
// register, and the data store read is registered alongside.
// Reset clears the presence map and the pipeline at once; the data store is not cleared,
// as a data word is only used for a key that has been inserted.
module ordered_key_set_successor_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [okss_pkg::CMD_W-1:0]  cmd_i,
  input  logic [okss_pkg::KEY_W-1:0]  key_i,
  input  logic [okss_pkg::DATA_W-1:0] data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        found_o,
  output logic [okss_pkg::KEY_W-1:0]  key_out_o,
  output logic [okss_pkg::DATA_W-1:0] data_out_o
);
  import okss_pkg::*;

  logic              s1_valid_q;
  logic [CMD_W-1:0]  s1_cmd_q;
  logic [KEY_W-1:0]  s1_key_q;
  logic [DATA_W-1:0] s1_data_q;
  logic              s1_adv;

  logic              s2_valid_q;
  logic              s2_found_q;
  logic [KEY_W-1:0]  s2_key_q;
  logic              s2_use_mem_q;
  logic [DATA_W-1:0] s2_data_q;

  okss_req_t         req;
  okss_upd_t         upd;
  okss_res_t         res;
  logic [DATA_W-1:0] ram_rdata;
  logic              s1_insert;

  // Stage handshakes: the first stage moves on whenever the result stage is free or drains.
  assign s1_adv     = s1_valid_q && (!s2_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign s1_insert  = (s1_cmd_q == CMD_INSERT);

  // Input stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // Input stage payload, loaded on each input transfer.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_cmd_q  <= cmd_i;
      s1_key_q  <= key_i;
      s1_data_q <= data_i;
    end
  end

  // Query and update of the presence map from the input stage.
  assign req.cmd = s1_cmd_q;
  assign req.key = s1_key_q;
  assign upd.we  = s1_adv && s1_insert;
  assign upd.key = s1_key_q;

  okss_presence u_presence (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .upd_i  (upd),
    .res_o  (res)
  );

  // Data store: inserts write, the answer's key is read as the item moves on.
  okss_data_ram u_data_ram (
    .clk_i   (clk_i),
    .we_i    (upd.we),
    .waddr_i (s1_key_q),
    .wdata_i (s1_data_q),
    .re_i    (s1_adv),
    .raddr_i (res.key),
    .rdata_o (ram_rdata)
  );

  // Result stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (!s2_valid_q || out_ready_i) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  // Result stage payload; inserts answer with their own data, other found keys from the store, misses with zero.
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_found_q   <= res.found;
      s2_key_q     <= res.key;
      s2_use_mem_q <= res.found && !s1_insert;
      s2_data_q    <= (res.found && s1_insert) ? s1_data_q : '0;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign found_o     = s2_found_q;
  assign key_out_o   = s2_key_q;
  assign data_out_o  = s2_use_mem_q ? ram_rdata : s2_data_q;

  // A result that was not found carries a zero data word.
  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (data_out_o == '0))
    else $error("data word not zero on a miss");

  // An item held in the input stage keeps its key until it moves on.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_key_q)))
    else $error("input stage item lost while stalled");

  // The input stage never advances into a stalled result stage.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !out_ready_i && s1_valid_q) |=> (s2_valid_q && s1_valid_q))
    else $error("result stage overwritten while stalled");

endmodule
